// File: hdl/hpd_pkg.sv
`timescale 1ns / 1ps
// Package for the hex packet deframer: phase codes, header and range
// characters, the result word type and the hex character decode.
// No dependencies.
package hpd_pkg;

	typedef enum logic [3:0] {
		PH_HUNT  = 4'd0,
		PH_LENHI = 4'd1,
		PH_LENLO = 4'd2,
		PH_CK0   = 4'd3,
		PH_CK1   = 4'd4,
		PH_CK2   = 4'd5,
		PH_CK3   = 4'd6,
		PH_DHI   = 4'd7,
		PH_DLO   = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		ST_BUSY    = 2'd0,
		ST_GOOD    = 2'd1,
		ST_BAD_CHK = 2'd2,
		ST_BAD_LEN = 2'd3
	} status_t;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] XOR_SEED = 8'hDE;

	typedef struct packed {
		logic        has_byte;
		logic [7:0]  data_byte;
		logic [8:0]  byte_index;
		logic [8:0]  frame_length;
		logic        last_of_frame;
		status_t     frame_status;
	} result_t;

	function automatic logic [7:0] hdr_char(input logic [1:0] pos);
		logic [7:0] r;
		unique case (pos)
			2'd0:    r = CH_H;
			2'd1:    r = CH_Z;
			2'd2:    r = CH_R;
			default: r = CH_US;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_val(input logic [7:0] c);
		logic [7:0] r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = c - 8'h57;
		end else begin
			r = c - 8'h37;
		end
		return r;
	endfunction

endpackage

// File: hdl/hpd_parser.sv
`timescale 1ns / 1ps
// Frame parser: header hunt, length and check word capture, payload
// decode and check. Uses hpd_pkg.
module hpd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_char,
	output logic              res_valid,
	output hpd_pkg::result_t  res
);

	hpd_pkg::phase_t phase_q, phase_d;
	logic [1:0]  hm_q, hm_d;
	logic [8:0]  len_q, len_d;
	logic [15:0] exp_q, exp_d;
	logic [7:0]  xor_q, xor_d;
	logic [8:0]  bytes_q, bytes_d;
	logic [7:0]  hn_q, hn_d;

	logic [7:0]  hv;
	logic [15:0] ck_next;
	logic [7:0]  byte_val;
	logic [7:0]  xor_next;
	logic [7:0]  hi_off;
	logic [7:0]  lo_off;
	logic        len_bad;
	logic        is_last;
	logic        ok_data;
	logic        ok_zero;
	logic        is_nl;

	assign is_nl    = (rx_char == hpd_pkg::CH_NL);
	assign hv       = hpd_pkg::hex_val(rx_char);
	assign ck_next  = {exp_q[11:0], 4'h0} | {8'h00, hv};
	assign byte_val = {hn_q[3:0], 4'h0} | hv;
	assign xor_next = xor_q ^ byte_val;
	assign hi_off   = hn_q - hpd_pkg::CH_AT;
	assign lo_off   = rx_char - hpd_pkg::CH_AT;
	assign len_bad  = (hn_q < hpd_pkg::CH_AT) || (hn_q > hpd_pkg::CH_O) ||
	                  (rx_char < hpd_pkg::CH_AT) || (rx_char > hpd_pkg::CH_US);
	assign is_last  = ({1'b0, bytes_q} + 10'd1) >= {1'b0, len_q};
	assign ok_data  = ({~xor_next, xor_next} == exp_q);
	assign ok_zero  = ({~xor_q, xor_q} == ck_next);

	always_comb begin
		phase_d = phase_q;
		hm_d    = hm_q;
		len_d   = len_q;
		exp_d   = exp_q;
		xor_d   = xor_q;
		bytes_d = bytes_q;
		hn_d    = hn_q;
		if (!is_nl) begin
			unique case (phase_q)
				hpd_pkg::PH_LENHI: begin
					hn_d    = rx_char;
					phase_d = hpd_pkg::PH_LENLO;
				end
				hpd_pkg::PH_LENLO: begin
					if (len_bad) begin
						phase_d = hpd_pkg::PH_HUNT;
						hm_d    = 2'd0;
						xor_d   = hpd_pkg::XOR_SEED;
						bytes_d = 9'd0;
					end else begin
						len_d   = {hi_off[3:0], lo_off[4:0]};
						exp_d   = 16'h0000;
						xor_d   = hpd_pkg::XOR_SEED;
						bytes_d = 9'd0;
						phase_d = hpd_pkg::PH_CK0;
					end
				end
				hpd_pkg::PH_CK0, hpd_pkg::PH_CK1, hpd_pkg::PH_CK2: begin
					exp_d   = ck_next;
					phase_d = hpd_pkg::phase_t'(phase_q + 4'd1);
				end
				hpd_pkg::PH_CK3: begin
					exp_d = ck_next;
					if (len_q == 9'd0) begin
						phase_d = hpd_pkg::PH_HUNT;
						hm_d    = 2'd0;
						xor_d   = hpd_pkg::XOR_SEED;
						bytes_d = 9'd0;
					end else begin
						phase_d = hpd_pkg::PH_DHI;
					end
				end
				hpd_pkg::PH_DHI: begin
					hn_d    = hv;
					phase_d = hpd_pkg::PH_DLO;
				end
				hpd_pkg::PH_DLO: begin
					if (is_last) begin
						phase_d = hpd_pkg::PH_HUNT;
						hm_d    = 2'd0;
						xor_d   = hpd_pkg::XOR_SEED;
						bytes_d = 9'd0;
					end else begin
						xor_d   = xor_next;
						bytes_d = bytes_q + 9'd1;
						phase_d = hpd_pkg::PH_DHI;
					end
				end
				default: begin
					phase_d = hpd_pkg::PH_HUNT;
					if (rx_char == hpd_pkg::hdr_char(hm_q)) begin
						if (hm_q == 2'd3) begin
							hm_d    = 2'd0;
							phase_d = hpd_pkg::PH_LENHI;
						end else begin
							hm_d = hm_q + 2'd1;
						end
					end else begin
						hm_d = (rx_char == hpd_pkg::CH_H) ? 2'd1 : 2'd0;
					end
				end
			endcase
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '{has_byte: 1'b0, data_byte: 8'h00, byte_index: 9'd0,
		              frame_length: 9'd0, last_of_frame: 1'b0,
		              frame_status: hpd_pkg::ST_BUSY};
		if (!is_nl) begin
			unique case (phase_q)
				hpd_pkg::PH_LENLO: begin
					if (len_bad) begin
						res_valid         = 1'b1;
						res.last_of_frame = 1'b1;
						res.frame_status  = hpd_pkg::ST_BAD_LEN;
					end
				end
				hpd_pkg::PH_CK3: begin
					if (len_q == 9'd0) begin
						res_valid         = 1'b1;
						res.last_of_frame = 1'b1;
						res.frame_status  = ok_zero ? hpd_pkg::ST_GOOD : hpd_pkg::ST_BAD_CHK;
					end
				end
				hpd_pkg::PH_DLO: begin
					res_valid        = 1'b1;
					res.has_byte     = 1'b1;
					res.data_byte    = byte_val;
					res.byte_index   = bytes_q;
					res.frame_length = len_q;
					if (is_last) begin
						res.last_of_frame = 1'b1;
						res.frame_status  = ok_data ? hpd_pkg::ST_GOOD : hpd_pkg::ST_BAD_CHK;
					end
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hpd_pkg::PH_HUNT;
			hm_q    <= 2'd0;
			len_q   <= 9'd0;
			exp_q   <= 16'h0000;
			xor_q   <= hpd_pkg::XOR_SEED;
			bytes_q <= 9'd0;
			hn_q    <= 8'h00;
		end else if (step) begin
			phase_q <= phase_d;
			hm_q    <= hm_d;
			len_q   <= len_d;
			exp_q   <= exp_d;
			xor_q   <= xor_d;
			bytes_q <= bytes_d;
			hn_q    <= hn_d;
		end
	end

endmodule

// File: hdl/hex_packet_deframer.sv
`timescale 1ns / 1ps
// Top level of the hex packet deframer: input register, parser, result register.
// Uses hpd_pkg and hpd_parser.
//
// Takes one received character per clock while the output side does not stall, and
// returns at most one result word per character, back to back when unstalled: the
// character sits in an input register, the parser updates its state and forms the
// result in one pass, and the result lands in an output register, so each result
// word passes both registers after its character is accepted. Newlines are dropped. After "HZR_",
// two length characters, four check characters and the hex payload, each
// decoded byte is sent with its index; the word that ends a frame has tlast
// set and carries the status (good, bad check word or bad length).
module hex_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [7:0] data_byte, [16:8] byte_index,
	                                   // [25:17] frame_length, [27:26] frame_status
	output logic        m_axis_tlast,
	output logic [0:0]  m_axis_tuser   // [0] has_byte
);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             res_valid;
	hpd_pkg::result_t res;
	logic             out_valid_q;
	hpd_pkg::result_t out_q;
	logic             out_free;
	logic             step;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && (!res_valid || out_free);
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
		end
	end

	hpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_char   (char_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'h0, out_q.frame_status, out_q.frame_length,
	                        out_q.byte_index, out_q.data_byte};
	assign m_axis_tlast  = out_q.last_of_frame;
	assign m_axis_tuser  = out_q.has_byte;

endmodule

// File: hdl/hpd_checker.sv
`timescale 1ns / 1ps
// Port checker for the hex packet deframer, bound to the top level.
// Uses only the top level ports.
module hpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [0:0]  m_axis_tuser
);

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
		$stable(m_axis_tuser))
		else $error("output word changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
		m_axis_tlast && m_axis_tdata[16:0] == 17'd0)
		else $error("word without a byte is not a frame end");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |->
		m_axis_tuser[0] && m_axis_tdata[27:26] == 2'd0)
		else $error("mid-frame word with status or without a byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[27:26] != 2'd0)
		else $error("frame end without status");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[27:26] == 2'd3 |->
		!m_axis_tuser[0] && m_axis_tdata[25:17] == 9'd0)
		else $error("bad length word carries data");

endmodule

bind hex_packet_deframer hpd_checker u_hpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

// File: bench/hex_packet_deframer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for hex_packet_deframer: directed rows, then random frames and noise.
// Predicts each result word in-bench (typed directed rows give theirs) and compares at the output stream. Uses hpd_pkg.
module hex_packet_deframer_tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic [7:0] HEADER [4] = '{hpd_pkg::CH_H, hpd_pkg::CH_Z,
		hpd_pkg::CH_R, hpd_pkg::CH_US};

	localparam hpd_pkg::result_t NO_WORD    = '0;
	localparam hpd_pkg::result_t BAD_LEN_W  = '{has_byte: 1'b0, data_byte: 8'h00,
		byte_index: 9'd0, frame_length: 9'd0, last_of_frame: 1'b1,
		frame_status: hpd_pkg::ST_BAD_LEN};
	localparam hpd_pkg::result_t EMPTY_GOOD = '{has_byte: 1'b0, data_byte: 8'h00,
		byte_index: 9'd0, frame_length: 9'd0, last_of_frame: 1'b1,
		frame_status: hpd_pkg::ST_GOOD};

	typedef struct packed {
		logic [7:0]       ch;
		logic             typed;
		hpd_pkg::result_t want;
	} script_row_t;

	localparam int SCRIPT_ROWS = 24;
	localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
		'{hpd_pkg::CH_H, 1'b0, NO_WORD}, '{hpd_pkg::CH_H, 1'b0, NO_WORD},
		'{hpd_pkg::CH_Z, 1'b0, NO_WORD}, '{hpd_pkg::CH_R, 1'b0, NO_WORD},
		'{hpd_pkg::CH_US, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
		'{8'h00, 1'b1, BAD_LEN_W},
		'{hpd_pkg::CH_H, 1'b0, NO_WORD}, '{hpd_pkg::CH_Z, 1'b0, NO_WORD},
		'{hpd_pkg::CH_R, 1'b0, NO_WORD}, '{hpd_pkg::CH_US, 1'b0, NO_WORD},
		'{hpd_pkg::CH_AT, 1'b0, NO_WORD}, '{8'h60, 1'b1, BAD_LEN_W},
		'{hpd_pkg::CH_H, 1'b0, NO_WORD}, '{hpd_pkg::CH_Z, 1'b0, NO_WORD},
		'{hpd_pkg::CH_R, 1'b0, NO_WORD}, '{hpd_pkg::CH_US, 1'b0, NO_WORD},
		'{hpd_pkg::CH_AT, 1'b0, NO_WORD}, '{hpd_pkg::CH_NL, 1'b0, NO_WORD},
		'{hpd_pkg::CH_AT, 1'b0, NO_WORD}, '{8'h32, 1'b0, NO_WORD},
		'{8'h31, 1'b0, NO_WORD}, '{8'h64, 1'b0, NO_WORD},
		'{8'h65, 1'b1, EMPTY_GOOD}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [0:0]  m_axis_tuser;

	int unsigned source_gap_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned newline_pct = 0;
	int unsigned glyph_noise_pct = 0;
	int unsigned chars_sent = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	hpd_pkg::result_t decoded_words [$];

	hpd_pkg::phase_t parse_phase = hpd_pkg::PH_HUNT;
	logic [1:0]  hunt_pos = 2'd0;
	logic [8:0]  frame_len = 9'd0;
	logic [15:0] check_word = 16'h0000;
	logic [7:0]  byte_xor = hpd_pkg::XOR_SEED;
	logic [8:0]  bytes_seen = 9'd0;
	logic [7:0]  nib_hold = 8'h00;

	hex_packet_deframer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] char_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return c - 8'h30;
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			return c - 8'h61 + 8'd10;
		end
		return c - 8'h41 + 8'd10;
	endfunction

	function automatic void rearm_hunt();
		parse_phase = hpd_pkg::PH_HUNT;
		hunt_pos = 2'd0;
		byte_xor = hpd_pkg::XOR_SEED;
		bytes_seen = 9'd0;
	endfunction

	function automatic bit deframe_char(input logic [7:0] c, output hpd_pkg::result_t w);
		logic [7:0] b;
		logic [8:0] idx;
		bit sum_ok;
		w = '0;
		if (c == hpd_pkg::CH_NL) begin
			return 1'b0;
		end
		case (parse_phase)
			hpd_pkg::PH_LENHI: begin
				nib_hold = c;
				parse_phase = hpd_pkg::PH_LENLO;
				return 1'b0;
			end
			hpd_pkg::PH_LENLO: begin
				if (nib_hold < hpd_pkg::CH_AT || nib_hold > hpd_pkg::CH_O ||
						c < hpd_pkg::CH_AT || c > hpd_pkg::CH_US) begin
					w.last_of_frame = 1'b1;
					w.frame_status = hpd_pkg::ST_BAD_LEN;
					rearm_hunt();
					return 1'b1;
				end
				frame_len = {4'(nib_hold - hpd_pkg::CH_AT), 5'(c - hpd_pkg::CH_AT)};
				check_word = 16'h0000;
				byte_xor = hpd_pkg::XOR_SEED;
				bytes_seen = 9'd0;
				parse_phase = hpd_pkg::PH_CK0;
				return 1'b0;
			end
			hpd_pkg::PH_CK0, hpd_pkg::PH_CK1, hpd_pkg::PH_CK2, hpd_pkg::PH_CK3: begin
				check_word = (check_word << 4) | {8'h00, char_value(c)};
				if (parse_phase != hpd_pkg::PH_CK3) begin
					parse_phase = hpd_pkg::phase_t'(parse_phase + 4'd1);
					return 1'b0;
				end
				if (frame_len == 9'd0) begin
					sum_ok = ({~byte_xor, byte_xor} == check_word);
					w.last_of_frame = 1'b1;
					w.frame_status = sum_ok ? hpd_pkg::ST_GOOD : hpd_pkg::ST_BAD_CHK;
					rearm_hunt();
					return 1'b1;
				end
				parse_phase = hpd_pkg::PH_DHI;
				return 1'b0;
			end
			hpd_pkg::PH_DHI: begin
				nib_hold = char_value(c);
				parse_phase = hpd_pkg::PH_DLO;
				return 1'b0;
			end
			hpd_pkg::PH_DLO: begin
				b = (nib_hold << 4) | char_value(c);
				idx = bytes_seen;
				byte_xor = byte_xor ^ b;
				bytes_seen = bytes_seen + 9'd1;
				w.has_byte = 1'b1;
				w.data_byte = b;
				w.byte_index = idx;
				w.frame_length = frame_len;
				if ({1'b0, idx} + 10'd1 >= {1'b0, frame_len}) begin
					sum_ok = ({~byte_xor, byte_xor} == check_word);
					w.last_of_frame = 1'b1;
					w.frame_status = sum_ok ? hpd_pkg::ST_GOOD : hpd_pkg::ST_BAD_CHK;
					rearm_hunt();
				end else begin
					w.frame_status = hpd_pkg::ST_BUSY;
					parse_phase = hpd_pkg::PH_DHI;
				end
				return 1'b1;
			end
			default: begin
				parse_phase = hpd_pkg::PH_HUNT;
				if (c == HEADER[hunt_pos]) begin
					if (hunt_pos == 2'd3) begin
						hunt_pos = 2'd0;
						parse_phase = hpd_pkg::PH_LENHI;
					end else begin
						hunt_pos = hunt_pos + 2'd1;
					end
				end else begin
					hunt_pos = (c == hpd_pkg::CH_H) ? 2'd1 : 2'd0;
				end
				return 1'b0;
			end
		endcase
	endfunction

	function automatic logic [7:0] any_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(255));
		end while (c == hpd_pkg::CH_NL);
		return c;
	endfunction

	function automatic logic [7:0] hex_glyph(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = 8'h30 + n;
		end else if ($urandom_range(3) == 0) begin
			c = 8'h41 + n - 8'd10;
		end else begin
			c = 8'h61 + n - 8'd10;
		end
		if ($urandom_range(99) < glyph_noise_pct) begin
			c = any_char();
		end
		return c;
	endfunction

	// Drive one character, sometimes after a newline, wait for the handshake, then predict.
	task automatic send_char(input logic [7:0] c, input bit typed = 1'b0,
			input hpd_pkg::result_t typed_word = '0);
		hpd_pkg::result_t w;
		if ($urandom_range(99) < newline_pct) begin
			send_char(hpd_pkg::CH_NL);
		end
		while ($urandom_range(99) < source_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		if (c != hpd_pkg::CH_NL) begin
			chars_sent++;
		end
		if (deframe_char(c, w)) begin
			decoded_words.push_back(typed ? typed_word : w);
		end
	endtask

	task automatic send_header();
		for (int i = 0; i < 4; i++) begin
			send_char(HEADER[i]);
		end
	endtask

	task automatic send_frame(input logic [8:0] len, input bit bad_sum);
		logic [7:0] body [$];
		logic [7:0] x;
		logic [15:0] sum;
		x = hpd_pkg::XOR_SEED;
		for (int i = 0; i < int'(len); i++) begin
			body.push_back(8'($urandom_range(255)));
			x = x ^ body[i];
		end
		sum = {~x, x};
		if (bad_sum) begin
			sum = sum ^ (16'd1 << $urandom_range(15));
		end
		send_header();
		send_char(hpd_pkg::CH_AT + {4'd0, len[8:5]});
		send_char(hpd_pkg::CH_AT + {3'd0, len[4:0]});
		for (int k = 3; k >= 0; k--) begin
			send_char(hex_glyph(sum[k*4 +: 4]));
		end
		foreach (body[i]) begin
			send_char(hex_glyph(body[i][7:4]));
			send_char(hex_glyph(body[i][3:0]));
		end
	endtask

	task automatic send_traffic(input int unsigned budget);
		int unsigned base;
		int unsigned pick;
		int unsigned r;
		logic [7:0] hi;
		logic [7:0] lo;
		base = chars_sent;
		while (chars_sent - base < budget) begin
			pick = $urandom_range(99);
			if (pick < 85) begin
				r = $urandom_range(99);
				if (r < 80) begin
					send_frame(9'($urandom_range(6)), pick >= 72);
				end else if (r < 97) begin
					send_frame(9'($urandom_range(40, 7)), pick >= 72);
				end else begin
					send_frame(9'($urandom_range(140, 41)), pick >= 72);
				end
			end else if (pick < 93) begin
				hi = any_char();
				lo = any_char();
				if (hi >= hpd_pkg::CH_AT && hi <= hpd_pkg::CH_O &&
						lo >= hpd_pkg::CH_AT && lo <= hpd_pkg::CH_US) begin
					lo = lo ^ 8'h80;
				end
				send_header();
				send_char(hi);
				send_char(lo);
			end else begin
				if ($urandom_range(1)) begin
					send_char(hpd_pkg::CH_H);
					send_char(hpd_pkg::CH_Z);
				end
				repeat ($urandom_range(6, 1)) begin
					send_char(any_char());
				end
			end
		end
	endtask

	task automatic drain_results();
		do begin
			@(posedge clk);
		end while (decoded_words.size() != 0);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		hpd_pkg::result_t got;
		hpd_pkg::result_t want;
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.has_byte = m_axis_tuser[0];
			got.data_byte = m_axis_tdata[7:0];
			got.byte_index = m_axis_tdata[16:8];
			got.frame_length = m_axis_tdata[25:17];
			got.last_of_frame = m_axis_tlast;
			got.frame_status = hpd_pkg::status_t'(m_axis_tdata[27:26]);
			if (decoded_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected word at %0t: tdata=%h tlast=%b tuser=%b",
						$realtime, m_axis_tdata, m_axis_tlast, m_axis_tuser);
				end
			end else begin
				want = decoded_words.pop_front();
				if (got.has_byte !== want.has_byte || got.data_byte !== want.data_byte
						|| got.byte_index !== want.byte_index
						|| got.frame_length !== want.frame_length
						|| got.last_of_frame !== want.last_of_frame
						|| got.frame_status !== want.frame_status) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t (expected/actual): has_byte %b/%b",
							$realtime, want.has_byte, got.has_byte);
						$display("  data_byte %h/%h byte_index %0d/%0d",
							want.data_byte, got.data_byte,
							want.byte_index, got.byte_index);
						$display("  frame_length %0d/%0d last %b/%b status %0d/%0d",
							want.frame_length, got.frame_length,
							want.last_of_frame, got.last_of_frame,
							want.frame_status, got.frame_status);
					end
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_ROWS; i++) begin
			send_char(SCRIPT[i].ch, SCRIPT[i].typed, SCRIPT[i].want);
		end

		newline_pct = 3;
		glyph_noise_pct = 2;
		source_gap_pct = 10;
		sink_stall_pct = 87;
		send_traffic(380);

		// Hold the source until the output side has caught up.
		s_axis_tvalid <= 1'b0;
		drain_results();

		source_gap_pct = 87;
		sink_stall_pct = 10;
		send_traffic(380);

		source_gap_pct = 0;
		sink_stall_pct = 0;
		send_traffic(390);

		s_axis_tvalid <= 1'b0;
		drain_results();
		repeat (8) @(posedge clk);
		if (decoded_words.size() != 0) begin
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
